FILE: hdl/atok_pkg.sv
// Shared codes, character constants and types for the assembly text tokenizer.
package atok_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int LINE_BITS_DEF  = 32;

  // Lexer modes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEC     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HEX     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_IDENT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STRING  = 3'd5;

  // Token kinds
  localparam logic [2:0] KIND_INT    = 3'd0;
  localparam logic [2:0] KIND_IDENT  = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_LPAREN = 3'd3;
  localparam logic [2:0] KIND_RPAREN = 3'd4;
  localparam logic [2:0] KIND_LBRACE = 3'd5;
  localparam logic [2:0] KIND_RBRACE = 3'd6;
  localparam logic [2:0] KIND_EOF    = 3'd7;

  // Result events
  localparam logic EV_TEXT     = 1'b0;
  localparam logic EV_COMPLETE = 1'b1;

  // Characters
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_LZ      = 8'h7A;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UZ      = 8'h5A;

  // Offset from the low nibble of 'a'..'f' to the digit value
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  typedef struct packed {
    logic [2:0] kind;
    logic       ev;
    logic       last;
  } res_ctl_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return (c == CH_PERIOD) || (c == CH_COMMA) || (c == CH_BANG) || (c == CH_SPACE);
  endfunction

endpackage

FILE: hdl/atok_lexer.sv
// Tokenizer state registers and the per-character step producing up to two results.
module atok_lexer import atok_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int LINE_BITS  = LINE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            ch,
  input  logic                  eot,
  output logic                  r0_vld,
  output res_ctl_t              r0_ctl,
  output logic [VALUE_BITS-1:0] r0_value,
  output logic [LINE_BITS-1:0]  r0_line,
  output logic                  r1_vld,
  output res_ctl_t              r1_ctl,
  output logic [VALUE_BITS-1:0] r1_value,
  output logic [LINE_BITS-1:0]  r1_line
);

  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [LINE_BITS-1:0]  line_r, line_nxt;
  logic [LINE_BITS-1:0]  start_r, start_nxt;

  logic                  do_idle;
  logic                  cl_en;
  res_ctl_t              cl_ctl;
  logic [VALUE_BITS-1:0] cl_val;
  logic                  sd_en;
  res_ctl_t              sd_ctl;
  logic [VALUE_BITS-1:0] sd_val;
  logic [LINE_BITS-1:0]  sd_line;
  logic                  closable;
  logic [VALUE_BITS-1:0] dig_val;
  logic [VALUE_BITS-1:0] hexl_val;
  logic [VALUE_BITS-1:0] ch_val;

  assign dig_val  = VALUE_BITS'(ch[3:0]);
  assign hexl_val = VALUE_BITS'(ch[3:0] + HEX_LETTER_OFS);
  assign ch_val   = VALUE_BITS'(ch);
  assign closable = (mode_r == MODE_DEC) || (mode_r == MODE_HEX) ||
                    (mode_r == MODE_IDENT) || (mode_r == MODE_STRING);

  // Completion result of whatever token is open
  always_comb begin
    cl_ctl.ev   = EV_COMPLETE;
    cl_ctl.last = 1'b0;
    cl_val      = '0;
    if ((mode_r == MODE_DEC) || (mode_r == MODE_HEX)) begin
      cl_ctl.kind = KIND_INT;
      cl_val      = acc_r;
    end else if (mode_r == MODE_IDENT) begin
      cl_ctl.kind = KIND_IDENT;
    end else begin
      cl_ctl.kind = KIND_STRING;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    acc_nxt     = acc_r;
    line_nxt    = line_r;
    start_nxt   = start_r;
    do_idle     = 1'b0;
    cl_en       = 1'b0;
    sd_en       = 1'b0;
    sd_ctl.kind = KIND_EOF;
    sd_ctl.ev   = EV_COMPLETE;
    sd_ctl.last = 1'b1;
    sd_val      = '0;
    sd_line     = line_r;

    if (eot) begin
      cl_en     = closable;
      sd_en     = 1'b1;
      mode_nxt  = MODE_IDLE;
      acc_nxt   = '0;
      line_nxt  = '0;
      start_nxt = '0;
    end else begin
      case (mode_r)
        MODE_COMMENT: begin
          if (ch == CH_NL) begin
            mode_nxt = MODE_IDLE;
            line_nxt = line_r + LINE_BITS'(1);
          end
        end
        MODE_DEC: begin
          if (is_dig(ch)) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + dig_val;
          end else if (ch == CH_X) begin
            mode_nxt = MODE_HEX;
            acc_nxt  = '0;
          end else begin
            cl_en   = 1'b1;
            do_idle = 1'b1;
          end
        end
        MODE_HEX: begin
          if (is_dig(ch)) begin
            acc_nxt = (acc_r << 4) + dig_val;
          end else if ((ch >= CH_LA) && (ch <= CH_LF)) begin
            acc_nxt = (acc_r << 4) + hexl_val;
          end else begin
            cl_en   = 1'b1;
            do_idle = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(ch) || is_dig(ch) || (ch == CH_UNDER)) begin
            sd_en       = 1'b1;
            sd_ctl.kind = KIND_IDENT;
            sd_ctl.ev   = EV_TEXT;
            sd_val      = ch_val;
            sd_line     = start_r;
          end else begin
            cl_en   = 1'b1;
            do_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if (is_alpha(ch) || is_dig(ch) || is_sym(ch)) begin
            sd_en       = 1'b1;
            sd_ctl.kind = KIND_STRING;
            sd_ctl.ev   = EV_TEXT;
            sd_val      = ch_val;
            sd_line     = start_r;
          end else if (ch == CH_QUOTE) begin
            cl_en    = 1'b1;
            mode_nxt = MODE_IDLE;
            acc_nxt  = '0;
          end else begin
            cl_en   = 1'b1;
            do_idle = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // Idle handling; a character that ended a token, other than a closing quote, lands here again
      if (do_idle) begin
        mode_nxt = MODE_IDLE;
        if (cl_en) begin
          acc_nxt = '0;
        end
        if (ch == CH_SEMI) begin
          mode_nxt = MODE_COMMENT;
        end else if (ch == CH_NL) begin
          line_nxt = line_r + LINE_BITS'(1);
        end else if (is_dig(ch)) begin
          mode_nxt  = MODE_DEC;
          acc_nxt   = dig_val;
          start_nxt = line_r;
        end else if (is_alpha(ch)) begin
          mode_nxt    = MODE_IDENT;
          start_nxt   = line_r;
          sd_en       = 1'b1;
          sd_ctl.kind = KIND_IDENT;
          sd_ctl.ev   = EV_TEXT;
          sd_val      = ch_val;
        end else if (ch == CH_QUOTE) begin
          mode_nxt  = MODE_STRING;
          start_nxt = line_r;
        end else if (ch == CH_LPAREN) begin
          sd_en       = 1'b1;
          sd_ctl.kind = KIND_LPAREN;
        end else if (ch == CH_RPAREN) begin
          sd_en       = 1'b1;
          sd_ctl.kind = KIND_RPAREN;
        end else if (ch == CH_LBRACE) begin
          sd_en       = 1'b1;
          sd_ctl.kind = KIND_LBRACE;
        end else if (ch == CH_RBRACE) begin
          sd_en       = 1'b1;
          sd_ctl.kind = KIND_RBRACE;
        end
      end
    end
  end

  // Completion goes first when both are present
  always_comb begin
    if (cl_en) begin
      r0_vld      = 1'b1;
      r0_ctl      = cl_ctl;
      r0_ctl.last = !sd_en;
      r0_value    = cl_val;
      r0_line     = start_r;
      r1_vld      = sd_en;
    end else begin
      r0_vld      = sd_en;
      r0_ctl      = sd_ctl;
      r0_value    = sd_val;
      r0_line     = sd_line;
      r1_vld      = 1'b0;
    end
    r1_ctl   = sd_ctl;
    r1_value = sd_val;
    r1_line  = sd_line;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      acc_r   <= '0;
      line_r  <= '0;
      start_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      line_r  <= line_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

FILE: hdl/assembly_text_tokenizer_unit.sv
// Tokenizer top level: input register, lexer step, output register and spill slot.
//
// Input channel: in_valid / in_stall carry one source byte (in_character) or an
// end-of-text mark (in_end_of_text) per transfer. Result channel: out_valid /
// out_stall carry one token event per transfer; out_last flags the final result
// produced by a given byte.
// A byte taken into the input register is stepped through the lexer, and its first
// result is registered in the output register. One byte per cycle is taken while
// out_stall is low and each byte yields at most one result; a byte that yields two
// results (a token completion followed by a new bracket or text character) holds
// off the next byte, the second result waiting in a one-entry spill slot.
// The accumulate path is a shift-and-add multiply by ten or sixteen, set by
// the single lexer step between the input register and the output register.
// Reset (synchronous, rst_n low) empties all registers and returns the lexer
// to idle with the line count at zero. End of text returns the lexer to idle with
// the line count at zero after emitting EOF. When out_stall is held, the output
// slot stays full and in_stall rises once a byte waits in the input register; no byte or result is lost.
module assembly_text_tokenizer_unit import atok_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int LINE_BITS  = LINE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_character,
  input  logic                  in_end_of_text,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_kind,
  output logic                  out_event_res,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [LINE_BITS-1:0]  out_token_line,
  output logic                  out_last
);

  logic                  inp_vld_r;
  logic [7:0]            inp_char_r;
  logic                  inp_eot_r;
  logic                  fire;
  logic                  out_take;

  logic                  r0_vld, r1_vld;
  res_ctl_t              r0_ctl, r1_ctl;
  logic [VALUE_BITS-1:0] r0_value, r1_value;
  logic [LINE_BITS-1:0]  r0_line, r1_line;

  logic                  out_vld_r, out_vld_nxt;
  res_ctl_t              out_ctl_r, out_ctl_nxt;
  logic [VALUE_BITS-1:0] out_val_r, out_val_nxt;
  logic [LINE_BITS-1:0]  out_line_r, out_line_nxt;

  logic                  pend_vld_r, pend_vld_nxt;
  res_ctl_t              pend_ctl_r;
  logic [VALUE_BITS-1:0] pend_val_r;
  logic [LINE_BITS-1:0]  pend_line_r;

  assign out_take = out_vld_r && !out_stall;
  // Step only when both result slots can absorb two results
  assign fire     = inp_vld_r && !pend_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = inp_vld_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_vld_r <= 1'b0;
    end else if (!in_stall) begin
      inp_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      inp_char_r <= in_character;
      inp_eot_r  <= in_end_of_text;
    end
  end

  atok_lexer #(
    .VALUE_BITS (VALUE_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (fire),
    .ch       (inp_char_r),
    .eot      (inp_eot_r),
    .r0_vld   (r0_vld),
    .r0_ctl   (r0_ctl),
    .r0_value (r0_value),
    .r0_line  (r0_line),
    .r1_vld   (r1_vld),
    .r1_ctl   (r1_ctl),
    .r1_value (r1_value),
    .r1_line  (r1_line)
  );

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_ctl_nxt  = out_ctl_r;
    out_val_nxt  = out_val_r;
    out_line_nxt = out_line_r;
    pend_vld_nxt = pend_vld_r;
    if (fire) begin
      // Output slot is empty or being drained; spill slot is empty
      out_vld_nxt  = r0_vld;
      out_ctl_nxt  = r0_ctl;
      out_val_nxt  = r0_value;
      out_line_nxt = r0_line;
      pend_vld_nxt = r1_vld;
    end else if (out_take) begin
      out_vld_nxt  = pend_vld_r;
      out_ctl_nxt  = pend_ctl_r;
      out_val_nxt  = pend_val_r;
      out_line_nxt = pend_line_r;
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ctl_r  <= out_ctl_nxt;
    out_val_r  <= out_val_nxt;
    out_line_r <= out_line_nxt;
    if (fire) begin
      pend_ctl_r  <= r1_ctl;
      pend_val_r  <= r1_value;
      pend_line_r <= r1_line;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_kind       = out_ctl_r.kind;
  assign out_event_res  = out_ctl_r.ev;
  assign out_value      = out_val_r;
  assign out_token_line = out_line_r;
  assign out_last       = out_ctl_r.last;

endmodule

FILE: bench/assembly_text_tokenizer_unit_tb.sv
// Self-checking bench for the text tokenizer: a directed table, then random source text.
module assembly_text_tokenizer_unit_tb;
  import atok_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int LB = LINE_BITS_DEF;
  localparam int SOURCE_ITEMS = 940;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int DEC_RADIX = 10;
  localparam int HEX_RADIX = 16;
  localparam int HEX_LETTER_BASE = 10;
  localparam int STEADY_FROM = 420;
  localparam int STEADY_TO = 540;

  typedef struct packed {
    logic [2:0]    kind;
    logic          ev;
    logic [VB-1:0] value;
    logic [LB-1:0] line;
    logic          last;
  } token_event_t;

  // typed rows carry their one expected result; other rows go through the lexer model
  typedef struct packed {
    logic [7:0]    ch;
    logic          eot;
    logic          typed;
    logic [2:0]    kind;
    logic [LB-1:0] line;
  } src_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_character = 8'h00;
  logic in_end_of_text = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_kind;
  logic out_event_res;
  logic [VB-1:0] out_value;
  logic [LB-1:0] out_token_line;
  logic out_last;

  logic steady_run = 1'b0;
  int stall_hold = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int results_checked = 0;
  int completions = 0;
  int text_chars = 0;
  int bytes_sent = 0;
  int eot_sent = 0;
  int two_result_bytes = 0;
  logic [7:0] kinds_seen = '0;

  // lexer model state
  logic [2:0]    lex_mode = MODE_IDLE;
  logic [VB-1:0] lex_acc = '0;
  logic [LB-1:0] lex_line = '0;
  logic [LB-1:0] lex_start = '0;

  token_event_t step_events[$];
  token_event_t lexed_events[$];
  src_row_t source_text[$];

  assembly_text_tokenizer_unit #(
    .VALUE_BITS(VB),
    .LINE_BITS(LB)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_character(in_character),
    .in_end_of_text(in_end_of_text),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_event_res(out_event_res),
    .out_value(out_value),
    .out_token_line(out_token_line),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic char_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic char_letter(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic char_punct(input logic [7:0] c);
    return c == CH_PERIOD || c == CH_COMMA || c == CH_BANG || c == CH_SPACE;
  endfunction

  function void push_event(input logic [2:0] kind, input logic ev,
                           input logic [VB-1:0] value, input logic [LB-1:0] line);
    token_event_t e;
    e.kind = kind;
    e.ev = ev;
    e.value = value;
    e.line = line;
    e.last = 1'b0;
    step_events.push_back(e);
  endfunction

  function void close_open_token();
    if (lex_mode == MODE_DEC || lex_mode == MODE_HEX)
      push_event(KIND_INT, EV_COMPLETE, lex_acc, lex_start);
    else if (lex_mode == MODE_IDENT)
      push_event(KIND_IDENT, EV_COMPLETE, '0, lex_start);
    else if (lex_mode == MODE_STRING)
      push_event(KIND_STRING, EV_COMPLETE, '0, lex_start);
    lex_mode = MODE_IDLE;
    lex_acc = '0;
  endfunction

  function void start_from_idle(input logic [7:0] c);
    logic [VB-1:0] cv;
    cv = VB'(c);
    if (c == CH_SEMI) begin
      lex_mode = MODE_COMMENT;
    end else if (c == CH_NL) begin
      lex_line = lex_line + LB'(1);
    end else if (char_digit(c)) begin
      lex_mode = MODE_DEC;
      lex_acc = VB'(c - CH_0);
      lex_start = lex_line;
    end else if (char_letter(c)) begin
      lex_mode = MODE_IDENT;
      lex_start = lex_line;
      push_event(KIND_IDENT, EV_TEXT, cv, lex_start);
    end else if (c == CH_QUOTE) begin
      lex_mode = MODE_STRING;
      lex_start = lex_line;
    end else if (c == CH_LPAREN) begin
      push_event(KIND_LPAREN, EV_COMPLETE, '0, lex_line);
    end else if (c == CH_RPAREN) begin
      push_event(KIND_RPAREN, EV_COMPLETE, '0, lex_line);
    end else if (c == CH_LBRACE) begin
      push_event(KIND_LBRACE, EV_COMPLETE, '0, lex_line);
    end else if (c == CH_RBRACE) begin
      push_event(KIND_RBRACE, EV_COMPLETE, '0, lex_line);
    end
    // stray period, underscore and anything else: dropped
  endfunction

  // Advances the lexer model by one transfer; results land in step_events.
  function void lex_byte(input logic [7:0] c, input logic eot);
    logic [VB-1:0] cv;
    cv = VB'(c);
    step_events.delete();
    if (eot) begin
      close_open_token();
      push_event(KIND_EOF, EV_COMPLETE, '0, lex_line);
      lex_mode = MODE_IDLE;
      lex_acc = '0;
      lex_line = '0;
      lex_start = '0;
    end else begin
      case (lex_mode)
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            lex_mode = MODE_IDLE;
            lex_line = lex_line + LB'(1);
          end
        end
        MODE_DEC: begin
          if (char_digit(c)) begin
            lex_acc = lex_acc * VB'(DEC_RADIX) + VB'(c - CH_0);
          end else if (c == CH_X) begin
            lex_mode = MODE_HEX;
            lex_acc = '0;
          end else begin
            close_open_token();
            start_from_idle(c);
          end
        end
        MODE_HEX: begin
          if (char_digit(c)) begin
            lex_acc = lex_acc * VB'(HEX_RADIX) + VB'(c - CH_0);
          end else if (c >= CH_LA && c <= CH_LF) begin
            lex_acc = lex_acc * VB'(HEX_RADIX) + VB'(c - CH_LA) + VB'(HEX_LETTER_BASE);
          end else begin
            close_open_token();
            start_from_idle(c);
          end
        end
        MODE_IDENT: begin
          if (char_letter(c) || char_digit(c) || c == CH_UNDER) begin
            push_event(KIND_IDENT, EV_TEXT, cv, lex_start);
          end else begin
            close_open_token();
            start_from_idle(c);
          end
        end
        MODE_STRING: begin
          if (char_letter(c) || char_digit(c) || char_punct(c)) begin
            push_event(KIND_STRING, EV_TEXT, cv, lex_start);
          end else if (c == CH_QUOTE) begin
            close_open_token();
          end else begin
            close_open_token();
            start_from_idle(c);
          end
        end
        default: begin
          lex_mode = MODE_IDLE;
          start_from_idle(c);
        end
      endcase
    end
  endfunction

  function void add_plain(input logic [7:0] ch, input logic eot);
    src_row_t row;
    row = '0;
    row.ch = ch;
    row.eot = eot;
    source_text.push_back(row);
  endfunction

  function void add_typed(input logic [7:0] ch, input logic eot, input logic [2:0] kind,
                          input logic [LB-1:0] line);
    src_row_t row;
    row.ch = ch;
    row.eot = eot;
    row.typed = 1'b1;
    row.kind = kind;
    row.line = line;
    source_text.push_back(row);
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1) == 0)
      return 8'(CH_LA + $urandom_range(0, 25));
    return 8'(CH_UA + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, HEX_RADIX - 1);
    if (r < DEC_RADIX)
      return 8'(CH_0 + r);
    return 8'(CH_LA + r - HEX_LETTER_BASE);
  endfunction

  // mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic string describe(input token_event_t e);
    return $sformatf("kind=%0d ev=%0d value=%h line=%0d last=%0d",
                     e.kind, e.ev, e.value, e.line, e.last);
  endfunction

  function void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s", msg);
  endfunction

  always @(posedge clk) begin
    if (steady_run) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
      stall_hold = idle_len();
    end
  end

  always @(posedge clk) begin
    token_event_t got;
    token_event_t want;
    string diffs;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got.kind = out_kind;
      got.ev = out_event_res;
      got.value = out_value;
      got.line = out_token_line;
      got.last = out_last;
      if (lexed_events.size() == 0) begin
        note_mismatch($sformatf("unexpected result: %s", describe(got)));
      end else begin
        want = lexed_events.pop_front();
        diffs = "";
        if (got.kind !== want.kind) diffs = {diffs, " kind"};
        if (got.ev !== want.ev) diffs = {diffs, " event"};
        if (got.value !== want.value) diffs = {diffs, " value"};
        if (got.line !== want.line) diffs = {diffs, " line"};
        if (got.last !== want.last) diffs = {diffs, " last"};
        if (diffs != "")
          note_mismatch($sformatf("result %0d,%s differ:\n  want %s\n  got  %s",
                                  results_checked, diffs, describe(want), describe(got)));
        results_checked++;
        if (got.ev === EV_COMPLETE) completions++;
        else text_chars++;
        if (!$isunknown(got.kind)) kinds_seen[got.kind] = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, lexed_events.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    src_row_t row;
    token_event_t e;
    int r;
    int n;
    int gap;

    // directed: brackets, ignored bytes, comment, stray period, dec to hex,
    // invalid hex digit, identifier, string closed by quote and early, end of text
    add_plain(8'h00, 1'b0);
    add_plain(8'hFF, 1'b0);
    add_typed(CH_LPAREN, 1'b0, KIND_LPAREN, '0);
    add_typed(CH_RPAREN, 1'b0, KIND_RPAREN, '0);
    add_typed(CH_LBRACE, 1'b0, KIND_LBRACE, '0);
    add_typed(CH_RBRACE, 1'b0, KIND_RBRACE, '0);
    add_plain(CH_NL, 1'b0);
    add_plain(CH_SEMI, 1'b0);
    add_plain(CH_LPAREN, 1'b0);
    add_plain(CH_NL, 1'b0);
    add_plain(CH_PERIOD, 1'b0);
    add_plain(CH_UNDER, 1'b0);
    add_plain(CH_9, 1'b0);
    add_plain(CH_0, 1'b0);
    add_plain(CH_X, 1'b0);
    add_plain(CH_LF, 1'b0);
    add_plain(8'(CH_LF + 1), 1'b0);
    add_plain(CH_UZ, 1'b0);
    add_plain(CH_QUOTE, 1'b0);
    add_plain(CH_UA, 1'b0);
    add_plain(CH_COMMA, 1'b0);
    add_plain(CH_QUOTE, 1'b0);
    add_plain(CH_QUOTE, 1'b0);
    add_plain(CH_NL, 1'b0);
    add_plain(CH_9, 1'b0);
    add_plain(8'hA5, 1'b1);
    add_typed(8'h5A, 1'b1, KIND_EOF, '0);

    // random source text: mostly well-formed tokens, some noise and broken ones
    while (source_text.size() < SOURCE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 18) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 4);
        repeat (n) add_plain(pick_digit(), 1'b0);
      end else if (r < 30) begin
        add_plain(pick_digit(), 1'b0);
        add_plain(CH_X, 1'b0);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
        repeat (n) add_plain(pick_hex(), 1'b0);
      end else if (r < 46) begin
        add_plain(pick_letter(), 1'b0);
        repeat ($urandom_range(0, 8)) begin
          n = $urandom_range(0, 9);
          add_plain(n < 6 ? pick_letter() : (n < 9 ? pick_digit() : CH_UNDER), 1'b0);
        end
      end else if (r < 61) begin
        add_plain(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 10)) begin
          n = $urandom_range(0, 9);
          if (n < 6) add_plain(pick_letter(), 1'b0);
          else if (n < 8) add_plain(pick_digit(), 1'b0);
          else begin
            case ($urandom_range(0, 3))
              0: add_plain(CH_PERIOD, 1'b0);
              1: add_plain(CH_COMMA, 1'b0);
              2: add_plain(CH_BANG, 1'b0);
              default: add_plain(CH_SPACE, 1'b0);
            endcase
          end
        end
        // a string is sometimes cut short by an arbitrary byte
        add_plain($urandom_range(0, 4) != 0 ? CH_QUOTE : 8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 74) begin
        case ($urandom_range(0, 3))
          0: add_plain(CH_LPAREN, 1'b0);
          1: add_plain(CH_RPAREN, 1'b0);
          2: add_plain(CH_LBRACE, 1'b0);
          default: add_plain(CH_RBRACE, 1'b0);
        endcase
      end else if (r < 81) begin
        add_plain(CH_SEMI, 1'b0);
        repeat ($urandom_range(0, 8)) begin
          n = $urandom_range(0, 255);
          add_plain(n == CH_NL ? CH_SPACE : 8'(n), 1'b0);
        end
        add_plain(CH_NL, 1'b0);
      end else if (r < 91) begin
        add_plain(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 93) begin
        add_plain(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        add_plain(CH_NL, 1'b0);
      end
      // separator; with none at all the next byte may end the token and start another, or run on into it
      n = $urandom_range(0, 9);
      if (n < 4) add_plain(CH_SPACE, 1'b0);
      else if (n < 6) add_plain(CH_NL, 1'b0);
    end
    add_plain(8'h00, 1'b1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < source_text.size(); i++) begin
      row = source_text[i];
      steady_run <= (i >= STEADY_FROM && i < STEADY_TO);
      if (i == 300 || i == 700) begin
        // hold off until the block has delivered everything
        in_valid <= 1'b0;
        @(posedge clk);
        while (lexed_events.size() != 0) @(posedge clk);
      end else if (!(i >= STEADY_FROM && i < STEADY_TO)) begin
        gap = idle_len();
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_valid <= 1'b1;
      in_character <= row.ch;
      in_end_of_text <= row.eot;
      @(posedge clk);
      while (in_stall !== 1'b0) @(posedge clk);
      // transfer taken at this edge
      lex_byte(row.ch, row.eot);
      if (row.typed) begin
        step_events.delete();
        push_event(row.kind, EV_COMPLETE, '0, row.line);
      end
      if (row.eot) eot_sent++;
      else bytes_sent++;
      if (step_events.size() > 1) two_result_bytes++;
      for (int k = 0; k < step_events.size(); k++) begin
        e = step_events[k];
        e.last = (k == step_events.size() - 1);
        lexed_events.push_back(e);
      end
    end
    in_valid <= 1'b0;
    steady_run <= 1'b1;

    while (lexed_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d source bytes and %0d end-of-text marks, %0d results checked",
             bytes_sent, eot_sent, results_checked);
    $display("completions %0d, streamed characters %0d, two-result bytes %0d, kinds seen %b",
             completions, text_chars, two_result_bytes, kinds_seen);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
